// ===== design/iprt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iprt_pkg
// Shared types, constants and helpers of the IPv4 route table
// ----------------------------------------------------------------------------
package iprt_pkg;

  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned TREE_N      = 1 << IDX_W;
  localparam int unsigned LVL_W       = 23;
  localparam int unsigned FULL_LEN    = 32;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [LVL_W-1:0] lvl_t;

  typedef struct packed {
    logic [31:0] dst;
    logic [31:0] gw;
    logic [5:0]  ml;
    logic [3:0]  ifc;
    logic [31:0] src;
    logic [15:0] met;
  } entry_t;

  typedef struct packed {
    logic wr;
    logic shift;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    MODE_WILD  = 2'd0,
    MODE_LPM   = 2'd1,
    MODE_IFACE = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_DEL    = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_IFDOWN = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EXISTS   = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    RC_BCAST   = 3'd0,
    RC_MCAST   = 3'd1,
    RC_LOCAL   = 3'd2,
    RC_UNREACH = 3'd3,
    RC_ANYCAST = 3'd4,
    RC_UNICAST = 3'd5
  } rclass_e;

  function automatic logic [31:0] len_to_mask(input logic [5:0] ml);
    logic [31:0] m;
    if (ml >= 6'(FULL_LEN)) begin
      m = '1;
    end else begin
      m = ~(32'hFFFF_FFFF >> ml[4:0]);
    end
    return m;
  endfunction

endpackage

// ===== design/ipv4_route_table_lpm_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_route_table_lpm_core
// Ordered IPv4 route table with longest prefix match lookup
// ----------------------------------------------------------------------------
// One transaction at a time. Each pass compares the request against every
// table slot at once, then a registered pairwise tree picks the winner.
// Interface down repeats one pass per removed route. Deletes close the gap by
// shifting the slots above the removed one down together.
module ipv4_route_table_lpm_core
  import iprt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [31:0] dst_addr_i,
  input  logic [31:0] gateway_i,
  input  logic [5:0]  mask_len_i,
  input  logic [3:0]  iface_i,
  input  logic [31:0] src_addr_i,
  input  logic [15:0] metric_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [2:0]  route_class_o,
  output logic [31:0] route_dst_o,
  output logic [31:0] route_gateway_o,
  output logic [5:0]  route_mask_len_o,
  output logic [3:0]  route_iface_o,
  output logic [31:0] route_src_o,
  output logic [15:0] route_metric_o,
  output logic [6:0]  removed_count_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_RED,
    S_ACT
  } state_e;

  state_e      state_q;
  logic [31:0] local_q [4];
  op_e         op_q;
  entry_t      req_q;
  cnt_t        count_q;
  idx_t        red_q;
  logic [6:0]  rm_q;
  logic        out_valid_q;
  logic [1:0]  status_q;
  logic [2:0]  class_q;
  entry_t      route_q;
  logic [6:0]  rmc_q;

  mode_e                       mode;
  cell_ctrl_t [TABLE_DEPTH-1:0] ctrl;
  entry_t                      cell_ent [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]      cell_vld;
  logic [TABLE_DEPTH-1:0]      cell_hit;
  lvl_t [TABLE_DEPTH-1:0]      cell_lvl;
  logic                        best_found;
  idx_t                        best_idx;
  logic                        out_free;
  logic                        do_write;
  logic                        do_shift;
  logic                        loop_again;
  entry_t                      best_ent;
  logic                        is_bcast;
  logic                        is_mcast;
  logic                        is_local;
  logic [1:0]                  status_d;
  logic [2:0]                  class_d;
  entry_t                      route_d;

  always_comb begin
    case (op_q)
      OP_LOOKUP: mode = MODE_LPM;
      OP_IFDOWN: mode = MODE_IFACE;
      default:   mode = MODE_WILD;
    endcase
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign best_ent = cell_ent[best_idx];
  assign is_bcast = (req_q.dst == '1) || (req_q.dst[31:24] == 8'd0);
  assign is_mcast = req_q.dst[31:28] == 4'hE;
  assign is_local = (local_q[0] != '0 && local_q[0] == req_q.dst) ||
                    (local_q[1] != '0 && local_q[1] == req_q.dst) ||
                    (local_q[2] != '0 && local_q[2] == req_q.dst) ||
                    (local_q[3] != '0 && local_q[3] == req_q.dst);

  always_comb begin
    do_write   = 1'b0;
    do_shift   = 1'b0;
    loop_again = 1'b0;
    if (state_q == S_ACT) begin
      case (op_q)
        OP_ADD: do_write = out_free && !best_found && count_q != CNT_W'(TABLE_DEPTH);
        OP_DEL: do_shift = out_free && best_found;
        OP_IFDOWN: begin
          loop_again = best_found && req_q.ifc != '0;
          do_shift   = loop_again;
        end
        default: ;
      endcase
    end
  end

  // result fields of the finished transaction
  always_comb begin
    status_d = ST_OK;
    class_d  = '0;
    route_d  = '0;
    case (op_q)
      OP_ADD: begin
        if (best_found) begin
          status_d = ST_EXISTS;
        end else if (count_q == CNT_W'(TABLE_DEPTH)) begin
          status_d = ST_FULL;
        end
      end
      OP_DEL: begin
        if (!best_found) begin
          status_d = ST_NOTFOUND;
        end
      end
      OP_LOOKUP: begin
        if (is_bcast) begin
          class_d = RC_BCAST;
        end else if (is_mcast) begin
          class_d = RC_MCAST;
        end else if (is_local) begin
          class_d = RC_LOCAL;
        end else if (!best_found) begin
          class_d = RC_UNREACH;
        end else begin
          route_d = best_ent;
          if (best_ent.ml < 6'(FULL_LEN) &&
              (req_q.dst | len_to_mask(best_ent.ml)) == '1) begin
            class_d = RC_ANYCAST;
          end else begin
            class_d = RC_UNICAST;
          end
        end
      end
      default: ;
    endcase
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    entry_t nb_ent;
    logic   nb_vld;
    if (i == TABLE_DEPTH - 1) begin : g_last
      assign nb_ent = '0;
      assign nb_vld = 1'b0;
    end else begin : g_mid
      assign nb_ent = cell_ent[(i+1) % TABLE_DEPTH];
      assign nb_vld = cell_vld[(i+1) % TABLE_DEPTH];
    end
    assign ctrl[i].wr    = do_write && (count_q == CNT_W'(i));
    assign ctrl[i].shift = do_shift && (IDX_W'(i) >= best_idx);

    iprt_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl[i]),
      .mode_i     (mode),
      .req_i      (req_q),
      .nb_entry_i (nb_ent),
      .nb_valid_i (nb_vld),
      .entry_o    (cell_ent[i]),
      .valid_o    (cell_vld[i]),
      .hit_o      (cell_hit[i]),
      .level_o    (cell_lvl[i])
    );
  end

  iprt_best u_best (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (state_q == S_CMP),
    .step_i  (state_q == S_RED),
    .found_i (cell_hit),
    .level_i (cell_lvl),
    .found_o (best_found),
    .idx_o   (best_idx)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 4; k++) begin
        local_q[k] <= '0;
      end
    end else if (cfg_we_i) begin
      local_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      op_q  <= op_e'(op_i);
      req_q <= '{dst: dst_addr_i, gw: gateway_i, ml: mask_len_i, ifc: iface_i,
                 src: src_addr_i, met: metric_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      red_q       <= '0;
      rm_q        <= '0;
      out_valid_q <= 1'b0;
      status_q    <= '0;
      class_q     <= '0;
      route_q     <= '0;
      rmc_q       <= '0;
    end else begin
      if (state_q == S_ACT && !loop_again && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          rm_q <= '0;
          if (in_valid_i) begin
            state_q <= S_CMP;
          end
        end
        S_CMP: begin
          red_q   <= '0;
          state_q <= S_RED;
        end
        S_RED: begin
          red_q <= red_q + 1'b1;
          if (red_q == IDX_W'(IDX_W - 1)) begin
            state_q <= S_ACT;
          end
        end
        S_ACT: begin
          if (loop_again) begin
            count_q <= count_q - 1'b1;
            if (rm_q != 7'd127) begin
              rm_q <= rm_q + 1'b1;
            end
            state_q <= S_CMP;
          end else if (out_free) begin
            status_q <= status_d;
            class_q  <= class_d;
            route_q  <= route_d;
            rmc_q    <= (op_q == OP_IFDOWN) ? rm_q : 7'd0;
            state_q  <= S_IDLE;
            case (op_q)
              OP_ADD: begin
                if (do_write) begin
                  count_q <= count_q + 1'b1;
                end
              end
              OP_DEL: begin
                if (best_found) begin
                  count_q <= count_q - 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o       = state_q != S_IDLE;
  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign route_class_o    = class_q;
  assign route_dst_o      = route_q.dst;
  assign route_gateway_o  = route_q.gw;
  assign route_mask_len_o = route_q.ml;
  assign route_iface_o    = route_q.ifc;
  assign route_src_o      = route_q.src;
  assign route_metric_o   = route_q.met;
  assign removed_count_o  = rmc_q;

endmodule

// ===== design/iprt_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iprt_cell
// One route table slot: holds an entry, matches it, shifts from its neighbor
// ----------------------------------------------------------------------------
module iprt_cell (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  iprt_pkg::cell_ctrl_t   ctrl_i,
  input  iprt_pkg::mode_e        mode_i,
  input  iprt_pkg::entry_t       req_i,
  input  iprt_pkg::entry_t       nb_entry_i,
  input  logic                   nb_valid_i,
  output iprt_pkg::entry_t       entry_o,
  output logic                   valid_o,
  output logic                   hit_o,
  output iprt_pkg::lvl_t         level_o
);
  import iprt_pkg::*;

  entry_t      ent_q;
  logic        vld_q;
  logic        wild_hit;
  logic        lpm_hit;
  logic        if_hit;
  logic [31:0] mask;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ctrl_i.shift) begin
      vld_q <= nb_valid_i;
    end else if (ctrl_i.wr) begin
      vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      ent_q <= nb_entry_i;
    end else if (ctrl_i.wr) begin
      ent_q <= req_i;
    end
  end

  always_comb begin
    mask     = len_to_mask(ent_q.ml);
    wild_hit = (ent_q.dst == req_i.dst) &&
               (ent_q.gw == '0 || ent_q.gw == req_i.gw) &&
               (ent_q.ml == '0 || ent_q.ml == req_i.ml) &&
               (ent_q.ifc == '0 || ent_q.ifc == req_i.ifc) &&
               (ent_q.src == '0 || ent_q.src == req_i.src) &&
               (ent_q.met == '0 || ent_q.met == req_i.met);
    lpm_hit  = (ent_q.dst & mask) == (req_i.dst & mask);
    if_hit   = ent_q.ifc == req_i.ifc;
    case (mode_i)
      MODE_WILD:  hit_o = vld_q && wild_hit;
      MODE_LPM:   hit_o = vld_q && lpm_hit;
      MODE_IFACE: hit_o = vld_q && if_hit;
      default:    hit_o = 1'b0;
    endcase
    level_o = (mode_i == MODE_LPM) ? {ent_q.ml, (ent_q.gw == '0), ~ent_q.met} : '0;
  end

  assign entry_o = ent_q;
  assign valid_o = vld_q;

endmodule

// ===== design/iprt_best.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iprt_best
// Registered pairwise reduction picking the highest level, earliest on ties
// ----------------------------------------------------------------------------
module iprt_best (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       load_i,
  input  logic                                       step_i,
  input  logic [iprt_pkg::TABLE_DEPTH-1:0]           found_i,
  input  iprt_pkg::lvl_t [iprt_pkg::TABLE_DEPTH-1:0] level_i,
  output logic                                       found_o,
  output iprt_pkg::idx_t                             idx_o
);
  import iprt_pkg::*;

  logic [TREE_N-1:0] fnd_q;
  lvl_t              lvl_q [TREE_N];
  idx_t              idx_q [TREE_N];

  for (genvar i = 0; i < TREE_N; i++) begin : g_node
    logic take_b;
    if (i < TREE_N / 2) begin : g_comb
      assign take_b = fnd_q[2*i+1] && (!fnd_q[2*i] || lvl_q[2*i+1] > lvl_q[2*i]);
    end else begin : g_none
      assign take_b = 1'b0;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        fnd_q[i] <= 1'b0;
      end else if (load_i) begin
        fnd_q[i] <= (i < TABLE_DEPTH) ? found_i[i % TABLE_DEPTH] : 1'b0;
      end else if (step_i) begin
        if (i < TREE_N / 2) begin
          fnd_q[i] <= fnd_q[(2*i) % TREE_N] || fnd_q[(2*i+1) % TREE_N];
        end else begin
          fnd_q[i] <= 1'b0;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (load_i) begin
        lvl_q[i] <= level_i[i % TABLE_DEPTH];
        idx_q[i] <= IDX_W'(i);
      end else if (step_i && i < TREE_N / 2) begin
        lvl_q[i] <= take_b ? lvl_q[(2*i+1) % TREE_N] : lvl_q[(2*i) % TREE_N];
        idx_q[i] <= take_b ? idx_q[(2*i+1) % TREE_N] : idx_q[(2*i) % TREE_N];
      end
    end
  end

  assign found_o = fnd_q[0];
  assign idx_o   = idx_q[0];

endmodule

// ===== sim/tb_ipv4_route_table_lpm_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ipv4_route_table_lpm_core
// Self-checking testbench of the route table: a route table predictor tracks
// adds, deletes and interface down events, and checks every result
// ----------------------------------------------------------------------------
module tb_ipv4_route_table_lpm_core;
  import iprt_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  rclass;
    logic [31:0] dst;
    logic [31:0] gw;
    logic [5:0]  ml;
    logic [3:0]  ifc;
    logic [31:0] src;
    logic [15:0] met;
    logic [6:0]  removed;
  } route_result_t;

  class route_scoreboard;
    logic [31:0]   local_addr [4];
    entry_t        routes [$];
    route_result_t pending [$];
    int            errors;

    function new();
      errors = 0;
      foreach (local_addr[k]) local_addr[k] = '0;
    endfunction

    function automatic int find_route(entry_t r);
      foreach (routes[k]) begin
        if (routes[k].dst == r.dst &&
            (routes[k].gw == 0 || routes[k].gw == r.gw) &&
            (routes[k].ml == 0 || routes[k].ml == r.ml) &&
            (routes[k].ifc == 0 || routes[k].ifc == r.ifc) &&
            (routes[k].src == 0 || routes[k].src == r.src) &&
            (routes[k].met == 0 || routes[k].met == r.met)) return k;
      end
      return -1;
    endfunction

    function automatic logic [31:0] prefix_mask(logic [5:0] ml);
      if (ml >= 32) return '1;
      if (ml == 0) return '0;
      return 32'hFFFF_FFFF << (32 - ml);
    endfunction

    function void note_request(op_e op, entry_t r);
      route_result_t res;
      int hit, cnt;
      logic found;
      logic [31:0] lvl, best_lvl, m;
      int best;
      res = '0;
      case (op)
        OP_ADD: begin
          if (find_route(r) >= 0) res.status = ST_EXISTS;
          else if (routes.size() >= TABLE_DEPTH) res.status = ST_FULL;
          else routes.push_back(r);
        end
        OP_DEL: begin
          hit = find_route(r);
          if (hit >= 0) routes.delete(hit);
          else res.status = ST_NOTFOUND;
        end
        OP_IFDOWN: begin
          cnt = 0;
          if (r.ifc != 0) begin
            for (int k = routes.size() - 1; k >= 0; k--) begin
              if (routes[k].ifc == r.ifc) begin
                routes.delete(k);
                cnt++;
              end
            end
          end
          res.removed = (cnt > 127) ? 7'd127 : 7'(cnt);
        end
        default: begin
          if (r.dst == '1 || r.dst[31:24] == 0) res.rclass = RC_BCAST;
          else if (r.dst[31:28] == 4'hE) res.rclass = RC_MCAST;
          else if ((local_addr[0] != 0 && local_addr[0] == r.dst) ||
                   (local_addr[1] != 0 && local_addr[1] == r.dst) ||
                   (local_addr[2] != 0 && local_addr[2] == r.dst) ||
                   (local_addr[3] != 0 && local_addr[3] == r.dst))
            res.rclass = RC_LOCAL;
          else begin
            found = 0;
            best = 0;
            best_lvl = 0;
            foreach (routes[k]) begin
              m = prefix_mask(routes[k].ml);
              if ((routes[k].dst & m) != (r.dst & m)) continue;
              lvl = {2'b0, routes[k].ml, 24'b0} | (routes[k].gw == 0 ? 32'h1_0000 : 0)
                    | (32'hFFFF - routes[k].met);
              if (!found || lvl > best_lvl) begin
                found = 1;
                best_lvl = lvl;
                best = k;
              end
            end
            if (!found) res.rclass = RC_UNREACH;
            else begin
              res.dst = routes[best].dst;
              res.gw  = routes[best].gw;
              res.ml  = routes[best].ml;
              res.ifc = routes[best].ifc;
              res.src = routes[best].src;
              res.met = routes[best].met;
              if (routes[best].ml < 32 && (r.dst | prefix_mask(routes[best].ml)) == '1)
                res.rclass = RC_ANYCAST;
              else res.rclass = RC_UNICAST;
            end
          end
        end
      endcase
      pending.push_back(res);
    endfunction

    function void check_result(route_result_t got);
      route_result_t e;
      if (pending.size() == 0) begin
        $error("result transaction with nothing expected");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.status !== e.status) begin
        $error("status exp %0d got %0d", e.status, got.status); errors++;
      end
      if (got.rclass !== e.rclass) begin
        $error("route_class exp %0d got %0d", e.rclass, got.rclass); errors++;
      end
      if (got.dst !== e.dst) begin
        $error("route_dst exp %h got %h", e.dst, got.dst); errors++;
      end
      if (got.gw !== e.gw) begin
        $error("route_gateway exp %h got %h", e.gw, got.gw); errors++;
      end
      if (got.ml !== e.ml) begin
        $error("route_mask_len exp %0d got %0d", e.ml, got.ml); errors++;
      end
      if (got.ifc !== e.ifc) begin
        $error("route_iface exp %0d got %0d", e.ifc, got.ifc); errors++;
      end
      if (got.src !== e.src) begin
        $error("route_src exp %h got %h", e.src, got.src); errors++;
      end
      if (got.met !== e.met) begin
        $error("route_metric exp %0d got %0d", e.met, got.met); errors++;
      end
      if (got.removed !== e.removed) begin
        $error("removed_count exp %0d got %0d", e.removed, got.removed); errors++;
      end
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 2_000_000;

  logic        clk_i, rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;
  logic        in_valid_i, in_stall_o;
  logic [1:0]  op_i;
  logic [31:0] dst_addr_i, gateway_i, src_addr_i;
  logic [5:0]  mask_len_i;
  logic [3:0]  iface_i;
  logic [15:0] metric_i;
  logic        out_valid_o, out_stall_i;
  logic [1:0]  status_o;
  logic [2:0]  route_class_o;
  logic [31:0] route_dst_o, route_gateway_o, route_src_o;
  logic [5:0]  route_mask_len_o;
  logic [3:0]  route_iface_o;
  logic [15:0] route_metric_o;
  logic [6:0]  removed_count_o;

  route_scoreboard route_sb;
  int  cycle_count;
  bit  hold_off;
  bit  stall_random;
  entry_t pool [16];
  logic [31:0] cfg_shadow [4];

  ipv4_route_table_lpm_core dut (.*);

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // result side: check at rising edge, change stall at falling edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      route_sb.check_result('{status_o, route_class_o, route_dst_o, route_gateway_o,
                              route_mask_len_o, route_iface_o, route_src_o,
                              route_metric_o, removed_count_o});
  end

  always @(negedge clk_i) begin
    if (!rst_ni) out_stall_i <= 1'b0;
    else if (hold_off) out_stall_i <= 1'b1;
    else if (!stall_random) out_stall_i <= 1'b0;
    else if ($urandom_range(0, 99) < 3) out_stall_i <= 1'b1;
    else if ($urandom_range(0, 99) < 30) out_stall_i <= 1'b0;
  end

  task automatic idle_cycles();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    repeat (n) @(negedge clk_i);
  endtask

  task automatic send_request(op_e op, entry_t r, bit gaps);
    @(negedge clk_i);
    if (gaps && $urandom_range(0, 2) == 0) idle_cycles();
    in_valid_i <= 1'b1;
    op_i <= op;
    dst_addr_i <= r.dst;
    gateway_i <= r.gw;
    mask_len_i <= r.ml;
    iface_i <= r.ifc;
    src_addr_i <= r.src;
    metric_i <= r.met;
    do @(posedge clk_i); while (in_stall_o);
    route_sb.note_request(op, r);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic write_local(int idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx[1:0];
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    route_sb.local_addr[idx] = val;
  endtask

  task automatic drain_results();
    while (route_sb.pending.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  function automatic entry_t random_route();
    entry_t r;
    r.dst = $urandom();
    r.gw  = ($urandom_range(0, 2) == 0) ? 32'h0 : $urandom();
    r.ml  = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 32));
    r.ifc = 4'($urandom_range(0, 15));
    r.src = ($urandom_range(0, 1) == 0) ? 32'h0 : $urandom();
    r.met = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535)) : 16'($urandom_range(0, 7));
    return r;
  endfunction

  // destination drawn near a known route or a local address, or at random
  function automatic logic [31:0] near_addr();
    entry_t p;
    logic [31:0] a;
    p = pool[$urandom_range(0, 15)];
    a = p.dst ^ ($urandom() & ~route_sb.prefix_mask(p.ml));
    case ($urandom_range(0, 9))
      0: a = $urandom();
      1: a = cfg_shadow[$urandom_range(0, 3)];
      2: a = p.dst | ~route_sb.prefix_mask(p.ml);
      default: ;
    endcase
    return a;
  endfunction

  task automatic random_phase(int count);
    entry_t r;
    int sel;
    for (int k = 0; k < count; k++) begin
      sel = $urandom_range(0, 99);
      r = pool[$urandom_range(0, 15)];
      if (sel < 35) begin
        if ($urandom_range(0, 3) == 0) r = random_route();
        else r.met = r.met ^ 16'($urandom_range(0, 1));
        send_request(OP_ADD, r, 1);
      end else if (sel < 50) begin
        if ($urandom_range(0, 4) == 0) r = random_route();
        send_request(OP_DEL, r, 1);
      end else if (sel < 55) begin
        r.ifc = 4'($urandom_range(0, 15));
        send_request(OP_IFDOWN, r, 1);
      end else begin
        r.dst = near_addr();
        send_request(OP_LOOKUP, r, 1);
      end
    end
  endtask

  initial begin
    route_sb = new();
    rst_ni = 0;
    hold_off = 0;
    stall_random = 0;
    cfg_we_i = 0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_valid_i = 0;
    op_i = OP_ADD;
    dst_addr_i = '0;
    gateway_i = '0;
    mask_len_i = '0;
    iface_i = '0;
    src_addr_i = '0;
    metric_i = '0;
    foreach (cfg_shadow[k]) cfg_shadow[k] = '0;
    foreach (pool[k]) pool[k] = random_route();
    repeat (3) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // directed part
    cfg_shadow = '{32'h0A00_0001, 32'hFFFF_FFFF, 32'h0, 32'hC0A8_0101};
    for (int k = 0; k < 4; k++) write_local(k, cfg_shadow[k]);
    send_request(OP_LOOKUP, '{32'h0A01_0203, 0, 0, 0, 0, 0}, 0);
    send_request(OP_ADD, '{32'h0A00_0000, 32'h0, 6'd8, 4'd1, 32'h0, 16'd10}, 0);
    send_request(OP_ADD, '{32'h0A00_0000, 32'h0, 6'd8, 4'd1, 32'h0, 16'd10}, 0);
    send_request(OP_ADD, '{32'h0A01_0000, 32'h0A00_00FE, 6'd16, 4'd2, 32'h1, 16'd5}, 0);
    send_request(OP_ADD, '{32'h0A01_0200, 32'h0, 6'd63, 4'd15, 32'hFFFF_FFFF, 16'hFFFF}, 0);
    send_request(OP_ADD, '{32'h0, 32'hFFFF_FFFF, 6'd0, 4'd0, 32'h0, 16'hFFFF}, 0);
    send_request(OP_LOOKUP, '{32'hFFFF_FFFF, 0, 0, 0, 0, 0}, 0);
    send_request(OP_LOOKUP, '{32'h00FF_FFFF, 0, 0, 0, 0, 0}, 0);
    send_request(OP_LOOKUP, '{32'hE000_0001, 0, 0, 0, 0, 0}, 0);
    send_request(OP_LOOKUP, '{32'hC0A8_0101, 0, 0, 0, 0, 0}, 0);
    send_request(OP_LOOKUP, '{32'h0A01_FFFF, 0, 0, 0, 0, 0}, 0);
    send_request(OP_LOOKUP, '{32'h0A01_0200, 0, 0, 0, 0, 0}, 0);
    send_request(OP_LOOKUP, '{32'h0AFF_0001, 0, 0, 0, 0, 0}, 0);
    send_request(OP_LOOKUP, '{32'h7F00_0001, 0, 0, 0, 0, 0}, 0);
    send_request(OP_DEL, '{32'h0B00_0000, 0, 6'd8, 0, 0, 0}, 0);
    send_request(OP_DEL, '{32'h0, 32'h5, 6'd3, 4'd3, 32'h9, 16'd9}, 0);
    send_request(OP_LOOKUP, '{32'h7F00_0001, 0, 0, 0, 0, 0}, 0);
    send_request(OP_IFDOWN, '{32'h0, 0, 0, 4'd0, 0, 0}, 0);
    send_request(OP_IFDOWN, '{32'h0, 0, 0, 4'd7, 0, 0}, 0);
    send_request(OP_IFDOWN, '{32'h0, 0, 0, 4'd1, 0, 0}, 0);
    // fill the table, then add past full and add a duplicate
    for (int k = 0; k < TABLE_DEPTH; k++)
      send_request(OP_ADD, '{32'h2000_0000 + k, 32'h0, 6'd32, 4'd9, 32'h0, 16'd1}, 0);
    send_request(OP_ADD, '{32'h3000_0000, 0, 6'd8, 4'd9, 0, 16'd1}, 0);
    send_request(OP_ADD, '{32'h2000_0000, 0, 6'd32, 4'd9, 0, 16'd1}, 0);
    send_request(OP_IFDOWN, '{32'h0, 0, 0, 4'd9, 0, 0}, 0);
    drain_results();

    // random phases, each with its own local addresses
    stall_random = 1;
    for (int ph = 0; ph < 4; ph++) begin
      for (int k = 0; k < 4; k++) begin
        case (ph)
          0: cfg_shadow[k] = pool[k].dst;
          1: cfg_shadow[k] = '0;
          2: cfg_shadow[k] = 32'hFFFF_FFFF;
          default: cfg_shadow[k] = $urandom();
        endcase
        write_local(k, cfg_shadow[k]);
      end
      if (ph == 2) begin
        fork
          begin
            hold_off = 1;
            repeat (300) @(negedge clk_i);
            hold_off = 0;
          end
          random_phase(280);
        join
      end else begin
        random_phase(280);
      end
      drain_results();
      foreach (pool[k]) if ($urandom_range(0, 1)) pool[k] = random_route();
    end

    if (route_sb.errors == 0 && route_sb.pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/iprt_pkg.sv
design/iprt_cell.sv
design/iprt_best.sv
design/ipv4_route_table_lpm_core.sv
sim/tb_ipv4_route_table_lpm_core.sv
